/* hw/rtl/suqt_pkg.sv */
`default_nettype none

package suqt_pkg;

	localparam int TIME_W  = 64;
	localparam int TOTAL_W = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_RETIRE = 1'b1;

	localparam logic CLASS_INTERNAL = 1'b0;
	localparam logic CLASS_EXTERNAL = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [TIME_W-1:0] event_time;
		logic              event_class;
	} req_t;

	typedef struct packed {
		logic [TIME_W-1:0]  next_time;
		logic [TIME_W-1:0]  retired_time;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] pending_count;
		logic [TOTAL_W-1:0] internal_total;
		logic [TOTAL_W-1:0] external_total;
	} rsp_t;

	// broadcast command to every cell of the chain
	typedef struct packed {
		logic cmp;
		logic ins;
		logic ret;
	} cell_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CMP    = 4'b0010,
		ST_APPLY  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/suqt_cell.sv */
`default_nettype none

module suqt_cell #(
	parameter int TIME_BITS = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  suqt_pkg::cell_cmd_t        cmd,
	input  wire  [TIME_BITS-1:0]       key,
	input  wire  [TIME_BITS-1:0]       left_time,
	input  wire                        left_valid,
	input  wire                        left_take,
	input  wire  [TIME_BITS-1:0]       right_time,
	input  wire                        right_valid,
	output logic [TIME_BITS-1:0]       cur_time,
	output logic                       cur_valid,
	output logic                       eq,
	output logic                       take
);
	import suqt_pkg::*;

	logic [TIME_BITS-1:0] time_q;
	logic                 valid_q;
	logic                 eq_q;
	logic                 gt_q;
	logic                 first_empty;

	// first free slot: empty with a valid neighbor on the left
	assign first_empty = !valid_q && left_valid;
	assign take        = gt_q || first_empty;

	assign cur_time  = time_q;
	assign cur_valid = valid_q;
	assign eq        = eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			eq_q    <= 1'b0;
			gt_q    <= 1'b0;
		end else begin
			if (cmd.cmp) begin
				eq_q <= valid_q && (time_q == key);
				gt_q <= valid_q && (time_q > key);
			end
			if (cmd.ins && first_empty) begin
				valid_q <= 1'b1;
			end else if (cmd.ret) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && take) begin
			time_q <= left_take ? left_time : key;
		end else if (cmd.ret) begin
			time_q <= right_time;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sorted_unique_time_queue_core.sv */
// Sorted time queue built as a chain of compare/shift cells.
// A request runs through the compare, apply and result states; rsp_valid
// rises as the result state ends. Requests stall until the sequencer is
// idle; the chain's broadcast compare and neighbor shift use separate states.
// Reset: asynchronous, clears slot valid bits, pending count and totals;
// stored slot times are not reset and are only read while valid.
`default_nettype none

module sorted_unique_time_queue_core #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  suqt_pkg::req_t     req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output suqt_pkg::rsp_t     rsp
);
	import suqt_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t               state_q;
	logic                 kind_q;
	logic                 class_q;
	logic [TIME_BITS-1:0] key_q;

	logic [CNT_W-1:0]     count_q;
	logic [TOTAL_W-1:0]   int_total_q;
	logic [TOTAL_W-1:0]   ext_total_q;
	logic [STAT_W-1:0]    status_q;
	logic [TIME_W-1:0]    retired_q;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// chain wiring
	logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_valid;
	logic [QUEUE_DEPTH-1:0] cell_eq;
	logic [QUEUE_DEPTH-1:0] cell_take;
	cell_cmd_t            cmd;

	logic                 accept;
	logic                 is_dup;
	logic                 is_full;
	logic                 is_empty;
	logic                 do_ins;
	logic                 do_ret;
	logic                 rsp_free;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// compare flags were registered by the cells during the compare cycle
	assign is_dup   = |cell_eq;
	assign is_full  = cell_valid[QUEUE_DEPTH-1];
	assign is_empty = !cell_valid[0];

	assign do_ins = (state_q == ST_APPLY) && (kind_q == KIND_INSERT) && !is_dup && !is_full;
	assign do_ret = (state_q == ST_APPLY) && (kind_q == KIND_RETIRE) && !is_empty;

	assign cmd.cmp = (state_q == ST_CMP);
	assign cmd.ins = do_ins;
	assign cmd.ret = do_ret;

	// the cell chain: each cell sees its left and right neighbor only
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TIME_BITS-1:0] l_time;
		logic                 l_valid;
		logic                 l_take;
		logic [TIME_BITS-1:0] r_time;
		logic                 r_valid;

		if (i == 0) begin : g_head
			// head of the chain: a virtual always-valid left neighbor
			assign l_time  = '0;
			assign l_valid = 1'b1;
			assign l_take  = 1'b0;
		end else begin : g_mid
			assign l_time  = cell_time[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_take  = cell_take[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_time  = '0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_time  = cell_time[i+1];
			assign r_valid = cell_valid[i+1];
		end

		suqt_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.key         (key_q),
			.left_time   (l_time),
			.left_valid  (l_valid),
			.left_take   (l_take),
			.right_time  (r_time),
			.right_valid (r_valid),
			.cur_time    (cell_time[i]),
			.cur_valid   (cell_valid[i]),
			.eq          (cell_eq[i]),
			.take        (cell_take[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					// wait here only while an older response is still held
					if (rsp_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture; time is cut to TIME_BITS
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			class_q <= req.event_class;
			key_q   <= req.event_time[TIME_BITS-1:0];
		end
	end

	// count and saturating totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			int_total_q <= '0;
			ext_total_q <= '0;
		end else if (state_q == ST_APPLY) begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_ret) begin
				count_q <= count_q - CNT_W'(1);
			end
			// a duplicate still counts; a dropped insert does not
			if (kind_q == KIND_INSERT && (is_dup || !is_full)) begin
				if (class_q == CLASS_EXTERNAL) begin
					if (ext_total_q != '1) ext_total_q <= ext_total_q + TOTAL_W'(1);
				end else begin
					if (int_total_q != '1) int_total_q <= int_total_q + TOTAL_W'(1);
				end
			end
		end
	end

	// status and retired time, taken before the chain shifts
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			retired_q <= '1;
			if (kind_q == KIND_INSERT) begin
				if (is_dup) begin
					status_q <= STAT_DUP;
				end else if (is_full) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_OK;
				end
			end else if (is_empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q  <= STAT_OK;
				retired_q <= TIME_W'(cell_time[0]);
			end
		end
	end

	// response register: pending count is reported modulo 128
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && rsp_free) begin
			rsp_q.next_time      <= cell_valid[0] ? TIME_W'(cell_time[0]) : '1;
			rsp_q.retired_time   <= retired_q;
			rsp_q.status         <= status_q;
			rsp_q.pending_count  <= count_ext[COUNT_W-1:0];
			rsp_q.internal_total <= int_total_q;
			rsp_q.external_total <= ext_total_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// valid bits form a prefix whose length is the pending count
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("pending count differs from cell valid bits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= QUEUE_DEPTH)
		else $error("pending count above depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not add one slot");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("response raised outside result cycle");

	a_no_dual_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_ins && do_ret))
		else $error("insert and retire in one cycle");
`endif

endmodule

`default_nettype wire
